>>> rtl/ldr_pkg.sv
// Shared types, constants and tables of the lidar return decoder.
package ldr_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_IDX_W       = 5;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_RAY    = 2'd1;
    localparam logic [1:0] PH_RETURN = 2'd2;
    localparam logic [1:0] PH_SKIP   = 2'd3;

    localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [27:0] PI_Q24      = 28'sd52707179;
    localparam logic signed [31:0] GAIN_Q30    = 32'sd652032874;
    localparam logic [29:0]        NS_PER_SEC  = 30'd1000000000;
    localparam logic signed [27:0] POS_MAX     = 28'sd16777215;
    localparam logic signed [17:0] DIR_MAX     = 18'sd16384;

    typedef enum logic [3:0] {
        ST_BYTES, ST_CLOAD, ST_CITER, ST_CSAVE, ST_FACT0,
        ST_FACT1, ST_TIME0, ST_TIME1, ST_POS, ST_RND
    } t_state;

    typedef struct packed {
        logic                  take;
        logic                  c_load;
        logic                  c_sel;
        logic                  c_step;
        logic [ATAN_IDX_W-1:0] c_idx;
        logic                  c_save;
        logic                  fact0;
        logic                  fact1;
        logic                  time0;
        logic                  time1;
        logic                  pos_mul;
        logic                  pos_rnd;
    } t_cmd;

    typedef struct packed {
        logic ray_end;
        logic ret_end;
        logic out_busy;
    } t_status;

    function automatic logic [23:0] atan_q24(input logic [ATAN_IDX_W-1:0] idx);
        logic [23:0] v;
        case (idx)
            5'd0:    v = 24'd13176795;
            5'd1:    v = 24'd7778716;
            5'd2:    v = 24'd4110060;
            5'd3:    v = 24'd2086331;
            5'd4:    v = 24'd1047214;
            5'd5:    v = 24'd524117;
            5'd6:    v = 24'd262123;
            5'd7:    v = 24'd131069;
            5'd8:    v = 24'd65536;
            5'd9:    v = 24'd32768;
            5'd10:   v = 24'd16384;
            5'd11:   v = 24'd8192;
            5'd12:   v = 24'd4096;
            5'd13:   v = 24'd2048;
            5'd14:   v = 24'd1024;
            5'd15:   v = 24'd512;
            5'd16:   v = 24'd256;
            5'd17:   v = 24'd128;
            5'd18:   v = 24'd64;
            5'd19:   v = 24'd32;
            5'd20:   v = 24'd16;
            5'd21:   v = 24'd8;
            5'd22:   v = 24'd4;
            5'd23:   v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/ldr_if.sv
// Byte request channel and point request channel of the decoder.
interface ldr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       last_byte;
    modport source (output valid, payload_byte, last_byte, input ready);
    modport sink   (input valid, payload_byte, last_byte, output ready);
endinterface

interface ldr_out_if;
    logic               valid;
    logic               ready;
    logic [63:0]        point_time;
    logic signed [24:0] x_pos;
    logic signed [24:0] y_pos;
    logic signed [24:0] z_pos;
    logic [23:0]        range_raw;
    logic [15:0]        reflectance_raw;
    logic [31:0]        angles_raw;
    logic [7:0]         return_position;
    logic [8:0]         scan_line;
    logic [7:0]         exist_pct;
    logic [12:0]        ray_flags;
    logic [23:0]        packet_tags;
    modport source (output valid, point_time, x_pos, y_pos, z_pos, range_raw,
                    reflectance_raw, angles_raw, return_position, scan_line,
                    exist_pct, ray_flags, packet_tags, input ready);
    modport sink   (input valid, point_time, x_pos, y_pos, z_pos, range_raw,
                    reflectance_raw, angles_raw, return_position, scan_line,
                    exist_pct, ray_flags, packet_tags, output ready);
endinterface

>>> rtl/ldr_ctrl.sv
// Sequencer of the decoder: byte intake, CORDIC steps, factor and point math.
module ldr_ctrl #(
    parameter int CORDIC_STEPS = ldr_pkg::CORDIC_STEPS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  ldr_pkg::t_status i_status,
    output ldr_pkg::t_cmd   o_cmd
);
    import ldr_pkg::*;

    localparam int CW = $clog2(CORDIC_STEPS);
    localparam logic [CW-1:0] LAST_STEP = CW'(CORDIC_STEPS - 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_sel, n_sel;
    logic          take;

    assign o_ready = (r_state == ST_BYTES) && !(i_status.out_busy && i_status.ret_end);
    assign take    = o_ready && i_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_BYTES: begin
                if (take && i_status.ray_end)      n_state = ST_CLOAD;
                else if (take && i_status.ret_end) n_state = ST_POS;
            end
            ST_CLOAD: n_state = ST_CITER;
            ST_CITER: if (r_cnt == LAST_STEP) n_state = ST_CSAVE;
            ST_CSAVE: n_state = r_sel ? ST_FACT0 : ST_CLOAD;
            ST_FACT0: n_state = ST_FACT1;
            ST_FACT1: n_state = ST_TIME0;
            ST_TIME0: n_state = ST_TIME1;
            ST_TIME1: n_state = ST_BYTES;
            ST_POS:   n_state = ST_RND;
            ST_RND:   n_state = ST_BYTES;
            default:  n_state = ST_BYTES;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        n_sel = r_sel;
        case (r_state)
            ST_BYTES: n_sel = 1'b0;
            ST_CLOAD: n_cnt = '0;
            ST_CITER: n_cnt = r_cnt + 1'b1;
            ST_CSAVE: n_sel = 1'b1;
            default:  n_sel = r_sel;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.take    = take;
        o_cmd.c_sel   = r_sel;
        o_cmd.c_idx   = ATAN_IDX_W'(r_cnt);
        case (r_state)
            ST_CLOAD: o_cmd.c_load  = 1'b1;
            ST_CITER: o_cmd.c_step  = 1'b1;
            ST_CSAVE: o_cmd.c_save  = 1'b1;
            ST_FACT0: o_cmd.fact0   = 1'b1;
            ST_FACT1: o_cmd.fact1   = 1'b1;
            ST_TIME0: o_cmd.time0   = 1'b1;
            ST_TIME1: o_cmd.time1   = 1'b1;
            ST_POS:   o_cmd.pos_mul = 1'b1;
            ST_RND:   o_cmd.pos_rnd = 1'b1;
            default:  o_cmd.take    = take;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_BYTES;
            r_cnt   <= '0;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
        end
    end

endmodule

>>> rtl/ldr_dp.sv
// Datapath of the decoder: byte parser, CORDIC unit, multipliers, point register.
module ldr_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    ldr_in_if.sink           i_in,
    ldr_out_if.source        o_pts,
    input  ldr_pkg::t_cmd    i_cmd,
    output ldr_pkg::t_status o_status
);
    import ldr_pkg::*;

    // parser state
    logic [3:0]   r_pos, n_pos;
    logic [1:0]   r_phase, n_phase;
    logic [127:0] r_hdr, n_hdr;
    logic [127:0] r_ray, n_ray;
    logic [63:0]  r_ret, n_ret;
    logic [7:0]   r_rays, n_rays;
    logic [3:0]   r_rd, n_rd;
    logic [3:0]   r_rd_snap;
    // CORDIC and factors
    logic signed [31:0] r_cx, r_cy, r_ca, r_sa, r_ce, r_se;
    logic signed [27:0] r_cz;
    logic               r_neg;
    logic signed [63:0] r_prod;
    logic signed [15:0] r_f0, r_f1, r_f2;
    logic [63:0]        r_tacc, r_base;
    logic signed [40:0] r_px, r_py, r_pz;
    logic               r_ovalid;

    logic [3:0]         nret;
    logic [15:0]        angle;
    logic signed [27:0] z0;
    logic signed [31:0] dx, dy;
    logic [23:0]        atan_v;
    logic [47:0]        ptp;
    logic [45:0]        hi_prod;
    logic signed [32:0] se_sum;
    logic signed [16:0] se_sh;

    function automatic logic signed [15:0] dir_rnd(input logic signed [63:0] p);
        logic signed [17:0] q;
        logic signed [63:0] s;
        s = (p + 64'sh2000_0000_0000) >>> 46;
        q = s[17:0];
        if (q > DIR_MAX)       q = DIR_MAX;
        else if (q < -DIR_MAX) q = -DIR_MAX;
        return q[15:0];
    endfunction

    function automatic logic signed [24:0] pos_rnd(input logic signed [40:0] p);
        logic signed [41:0] s;
        logic signed [27:0] q;
        s = ($signed({p[40], p}) + 42'sd8192) >>> 14;
        q = s[27:0];
        if (q > POS_MAX)       q = POS_MAX;
        else if (q < -POS_MAX) q = -POS_MAX;
        return q[24:0];
    endfunction

    assign nret     = r_ray[79:76];
    assign o_status = '{ray_end: (r_phase == PH_RAY) && (r_pos == 4'd15),
                        ret_end: (r_phase == PH_RETURN) && (r_pos[2:0] == 3'd7),
                        out_busy: r_ovalid};

    // byte parser
    always_comb begin
        n_pos   = r_pos;
        n_phase = r_phase;
        n_hdr   = r_hdr;
        n_ray   = r_ray;
        n_ret   = r_ret;
        n_rays  = r_rays;
        n_rd    = r_rd;
        case (r_phase)
            PH_HEADER: begin
                n_hdr[{r_pos, 3'b000} +: 8] = i_in.payload_byte;
                if (r_pos == 4'd15) begin
                    n_rays  = r_hdr[39:32];
                    n_phase = (r_hdr[7:0] == 8'd1 && r_hdr[15:8] == 8'd3
                               && r_hdr[39:32] != 8'd0) ? PH_RAY : PH_SKIP;
                    n_pos   = '0;
                end else begin
                    n_pos = r_pos + 4'd1;
                end
            end
            PH_RAY: begin
                n_ray[{r_pos, 3'b000} +: 8] = i_in.payload_byte;
                if (r_pos == 4'd15) begin
                    n_rays  = r_rays - 8'd1;
                    n_rd    = '0;
                    n_phase = (n_ray[79:76] != 4'd0) ? PH_RETURN
                            : ((n_rays != 8'd0) ? PH_RAY : PH_SKIP);
                    n_pos   = '0;
                end else begin
                    n_pos = r_pos + 4'd1;
                end
            end
            PH_RETURN: begin
                n_ret[{r_pos[2:0], 3'b000} +: 8] = i_in.payload_byte;
                if (r_pos[2:0] == 3'd7) begin
                    n_rd  = r_rd + 4'd1;
                    n_pos = '0;
                    if (n_rd >= nret) n_phase = (r_rays != 8'd0) ? PH_RAY : PH_SKIP;
                end else begin
                    n_pos = {1'b0, r_pos[2:0] + 3'd1};
                end
            end
            default: n_phase = r_phase;
        endcase
        if (i_in.last_byte) begin
            n_pos   = '0;
            n_phase = PH_HEADER;
            n_rays  = '0;
            n_rd    = '0;
        end
    end

    // CORDIC helpers
    assign angle  = i_cmd.c_sel ? r_ray[31:16] : r_ray[15:0];
    assign z0     = {{2{angle[15]}}, angle, 10'b0};
    assign dx     = r_cy >>> i_cmd.c_idx;
    assign dy     = r_cx >>> i_cmd.c_idx;
    assign atan_v = atan_q24(i_cmd.c_idx);
    assign ptp    = {r_hdr[95:64], r_hdr[63:48]};
    assign hi_prod = ptp[47:32] * NS_PER_SEC;
    assign se_sum = $signed({r_se[31], r_se}) + 33'sd32768;
    assign se_sh  = se_sum[32:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_phase  <= PH_HEADER;
            r_hdr    <= '0;
            r_ray    <= '0;
            r_ret    <= '0;
            r_rays   <= '0;
            r_rd     <= '0;
            r_f0     <= '0;
            r_f1     <= '0;
            r_f2     <= '0;
            r_base   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_pos   <= n_pos;
                r_phase <= n_phase;
                r_hdr   <= n_hdr;
                r_ray   <= n_ray;
                r_ret   <= n_ret;
                r_rays  <= n_rays;
                r_rd    <= n_rd;
            end
            if (i_cmd.fact1) r_f0 <= dir_rnd(r_prod);
            if (i_cmd.time0) begin
                r_f1 <= dir_rnd(r_prod);
                if (se_sh > 17'sd16384)       r_f2 <= 16'sd16384;
                else if (se_sh < -17'sd16384) r_f2 <= -16'sd16384;
                else                          r_f2 <= se_sh[15:0];
            end
            if (i_cmd.time1)
                r_base <= r_tacc + {hi_prod[31:0], 32'b0} + {32'b0, r_ray[63:32]};
            if (i_cmd.pos_rnd)                     r_ovalid <= 1'b1;
            else if (o_pts.valid && o_pts.ready)   r_ovalid <= 1'b0;
        end
    end

    // datapath registers without reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && o_status.ret_end) r_rd_snap <= r_rd;
        if (i_cmd.c_load) begin
            r_cx <= GAIN_Q30;
            r_cy <= '0;
            if (z0 > HALF_PI_Q24) begin
                r_cz <= z0 - PI_Q24;  r_neg <= 1'b1;
            end else if (z0 < -HALF_PI_Q24) begin
                r_cz <= z0 + PI_Q24;  r_neg <= 1'b1;
            end else begin
                r_cz <= z0;           r_neg <= 1'b0;
            end
        end else if (i_cmd.c_step) begin
            if (!r_cz[27]) begin
                r_cx <= r_cx - dx;
                r_cy <= r_cy + dy;
                r_cz <= r_cz - $signed({4'b0, atan_v});
            end else begin
                r_cx <= r_cx + dx;
                r_cy <= r_cy - dy;
                r_cz <= r_cz + $signed({4'b0, atan_v});
            end
        end
        if (i_cmd.c_save) begin
            if (i_cmd.c_sel) begin
                r_ce <= r_neg ? -r_cx : r_cx;
                r_se <= r_neg ? -r_cy : r_cy;
            end else begin
                r_ca <= r_neg ? -r_cx : r_cx;
                r_sa <= r_neg ? -r_cy : r_cy;
            end
        end
        if (i_cmd.fact0) r_prod <= r_ce * r_ca;
        if (i_cmd.fact1) r_prod <= r_ce * r_sa;
        if (i_cmd.time0) r_tacc <= {32'b0, ptp[31:0]} * {34'b0, NS_PER_SEC};
        if (i_cmd.pos_mul) begin
            r_px <= $signed({1'b0, r_ret[31:8]}) * r_f0;
            r_py <= $signed({1'b0, r_ret[31:8]}) * r_f1;
            r_pz <= $signed({1'b0, r_ret[31:8]}) * r_f2;
        end
        if (i_cmd.pos_rnd) begin
            o_pts.point_time      <= r_base;
            o_pts.x_pos           <= pos_rnd(r_px);
            o_pts.y_pos           <= pos_rnd(r_py);
            o_pts.z_pos           <= pos_rnd(r_pz);
            o_pts.range_raw       <= r_ret[31:8];
            o_pts.reflectance_raw <= r_ret[47:32];
            o_pts.angles_raw      <= r_ray[31:0];
            o_pts.return_position <= {nret, r_rd_snap};
            o_pts.scan_line       <= r_ray[95:87];
            o_pts.exist_pct       <= r_ret[7:0];
            o_pts.ray_flags       <= {r_ray[71:64], r_ray[84:81], r_ray[80]};
            o_pts.packet_tags     <= {r_hdr[111:104], r_hdr[47:40], r_hdr[103:96]};
        end
    end

    assign o_pts.valid = r_ovalid;

endmodule

>>> rtl/lidar_return_decoder_unit.sv
// Top level of the lidar return decoder.
// Decodes a lidar UDP point payload fed one byte per request (with a last-byte
// mark) and emits one point request per complete 8-byte return. Header and
// return bytes are taken at one byte per cycle. Each completed 16-byte ray
// header holds the byte input while the shared CORDIC unit computes azimuth
// and elevation terms and the multipliers form the direction factors and the
// ray timestamp. Each completed return holds the byte input for the product,
// then the rounding into the output register. A finished point waits in the
// output register while the next return's bytes are taken; only the byte that
// would complete a further return waits for it to drain. Reset is synchronous,
// active low.
module lidar_return_decoder_unit #(
    parameter int CORDIC_STEPS = ldr_pkg::CORDIC_STEPS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ldr_in_if.sink     i_in,
    ldr_out_if.source  o_pts
);
    import ldr_pkg::*;

    t_cmd    cmd;
    t_status status;

    ldr_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .o_ready  (i_in.ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    ldr_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_pts    (o_pts),
        .i_cmd    (cmd),
        .o_status (status)
    );

endmodule

>>> dv/lidar_return_decoder_unit_tb.sv
// Testbench for the lidar return decoder: byte-serial packets in, predicted points checked out.
`timescale 1ns / 1ps

module lidar_return_decoder_unit_tb;
    import ldr_pkg::*;

    localparam int  STEPS       = CORDIC_STEPS_DEF;
    localparam int  TAIL_CYCLES = 2 * (STEPS + 2) + 4 + 60;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  BYTE_GOAL   = 1250;
    localparam longint ARCTAN [24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef struct packed {
        logic [63:0] point_time;
        logic [24:0] x_pos;
        logic [24:0] y_pos;
        logic [24:0] z_pos;
        logic [23:0] range_raw;
        logic [15:0] reflectance_raw;
        logic [31:0] angles_raw;
        logic [7:0]  return_position;
        logic [8:0]  scan_line;
        logic [7:0]  exist_pct;
        logic [12:0] ray_flags;
        logic [23:0] packet_tags;
    } point_t;

    // Predicts the point stream from the accepted byte requests and holds the
    // points still due from the block.
    class point_board;
        bit [3:0]    pos;
        logic [1:0]  phase;
        bit [63:0]   hdr [2];
        bit [63:0]   ray [2];
        bit [63:0]   ret;
        bit [7:0]    rays_left;
        bit [3:0]    rets_seen;
        bit [15:0]   dir [3];
        bit [63:0]   base_ns;
        point_t      due_q [$];
        int          errors;
        int          points_seen;

        function new();
            pos = 0;
            phase = PH_HEADER;
            hdr = '{64'd0, 64'd0};
            ray = '{64'd0, 64'd0};
            ret = 0;
            rays_left = 0;
            rets_seen = 0;
            dir = '{16'd0, 16'd0, 16'd0};
            base_ns = 0;
            errors = 0;
            points_seen = 0;
        endfunction

        function bit [63:0] put(bit [63:0] w, int p, bit [7:0] b);
            if (p % 8 == 0) w = 0;
            w[8 * (p % 8) +: 8] = b;
            return w;
        endfunction

        // Q30 cos and sin of a Q2.14 angle
        function void rotate(bit [15:0] ang, output longint c, output longint s);
            longint z, x, y, dx, dy;
            bit     flip;
            z = longint'($signed(ang)) * 1024;
            x = 652032874;
            y = 0;
            flip = 0;
            if (z > 26353589) begin
                z -= 52707179;
                flip = 1;
            end else if (z < -26353589) begin
                z += 52707179;
                flip = 1;
            end
            for (int i = 0; i < STEPS && i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= ARCTAN[i];
                end else begin
                    x += dx; y -= dy; z += ARCTAN[i];
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function bit [15:0] dir_term(longint a, longint b);
            longint p;
            p = (a * b + (longint'(1) <<< 45)) >>> 46;
            if (p > 16384) p = 16384;
            if (p < -16384) p = -16384;
            return p[15:0];
        endfunction

        function bit [24:0] coord(bit [23:0] rng, bit [15:0] f);
            longint p;
            p = (longint'(rng) * longint'($signed(f)) + 8192) >>> 14;
            if (p > 16777215) p = 16777215;
            if (p < -16777215) p = -16777215;
            return p[24:0];
        endfunction

        function void note_byte(bit [7:0] b, bit last);
            longint  ca, sa, ce, se;
            bit [63:0] ptp;
            bit [3:0]  nret;
            bit [23:0] rng;
            point_t    pt;
            nret = ray[1][15:12];
            case (phase)
                PH_HEADER: begin
                    hdr[pos[3]] = put(hdr[pos[3]], pos, b);
                    if (pos == 15) begin
                        rays_left = hdr[0][39:32];
                        phase = (hdr[0][7:0] == 1 && hdr[0][15:8] == 3 && rays_left != 0)
                                ? PH_RAY : PH_SKIP;
                        pos = 0;
                    end else pos++;
                end
                PH_RAY: begin
                    ray[pos[3]] = put(ray[pos[3]], pos, b);
                    if (pos == 15) begin
                        ptp = (hdr[0] >> 48) | ({32'd0, hdr[1][31:0]} << 16);
                        rotate(ray[0][15:0], ca, sa);
                        rotate(ray[0][31:16], ce, se);
                        dir[0] = dir_term(ce, ca);
                        dir[1] = dir_term(ce, sa);
                        dir[2] = dir_term(se, longint'(1) <<< 30);
                        base_ns = ptp * 64'd1000000000 + {32'd0, ray[0][63:32]};
                        rets_seen = 0;
                        rays_left--;
                        nret = ray[1][15:12];
                        phase = (nret != 0) ? PH_RETURN : (rays_left != 0 ? PH_RAY : PH_SKIP);
                        pos = 0;
                    end else pos++;
                end
                PH_RETURN: begin
                    ret = put(ret, pos[2:0], b);
                    if (pos[2:0] == 7) begin
                        rng = ret[31:8];
                        pt.point_time      = base_ns;
                        pt.x_pos           = coord(rng, dir[0]);
                        pt.y_pos           = coord(rng, dir[1]);
                        pt.z_pos           = coord(rng, dir[2]);
                        pt.range_raw       = rng;
                        pt.reflectance_raw = ret[47:32];
                        pt.angles_raw      = ray[0][31:0];
                        pt.return_position = {nret, rets_seen};
                        pt.scan_line       = ray[1][31:23];
                        pt.exist_pct       = ret[7:0];
                        pt.ray_flags       = {ray[1][7:0], ray[1][20:17], ray[1][16]};
                        pt.packet_tags     = {hdr[1][47:40], hdr[0][47:40], hdr[1][39:32]};
                        due_q.insert(due_q.size(), pt);
                        rets_seen++;
                        pos = 0;
                        if (rets_seen >= nret) phase = (rays_left != 0) ? PH_RAY : PH_SKIP;
                    end else pos = {1'b0, pos[2:0] + 3'd1};
                end
                default: ;
            endcase
            if (last) begin
                pos = 0;
                phase = PH_HEADER;
                rays_left = 0;
                rets_seen = 0;
            end
        endfunction

        function void cmp(string nm, bit [63:0] e, bit [63:0] a);
            if (e !== a) begin
                $display("%0t: %s expected %h actual %h", $time, nm, e, a);
                errors++;
            end
        endfunction

        function void check_point(point_t a);
            point_t e;
            points_seen++;
            if (due_q.size() == 0) begin
                $display("%0t: point with none expected, actual %h", $time, a);
                errors++;
                return;
            end
            e = due_q[0];
            due_q.delete(0);
            cmp("point_time", e.point_time, a.point_time);
            cmp("x_pos", e.x_pos, a.x_pos);
            cmp("y_pos", e.y_pos, a.y_pos);
            cmp("z_pos", e.z_pos, a.z_pos);
            cmp("range_raw", e.range_raw, a.range_raw);
            cmp("reflectance_raw", e.reflectance_raw, a.reflectance_raw);
            cmp("angles_raw", e.angles_raw, a.angles_raw);
            cmp("return_position", e.return_position, a.return_position);
            cmp("scan_line", e.scan_line, a.scan_line);
            cmp("exist_pct", e.exist_pct, a.exist_pct);
            cmp("ray_flags", e.ray_flags, a.ray_flags);
            cmp("packet_tags", e.packet_tags, a.packet_tags);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    ldr_in_if  in_ch ();
    ldr_out_if pts_ch ();

    lidar_return_decoder_unit #(.CORDIC_STEPS(STEPS)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_pts   (pts_ch)
    );

    point_board board = new();
    bit [7:0]   pkt_q [$];
    int         burst_left;
    int         bytes_sent;
    int         cycles;

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // run guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: steps through four ready patterns: always, random half, sparse periodic, mostly ready
    always @(posedge i_clk) begin
        if (!i_rst_n) pts_ch.ready <= 1'b0;
        else case ((cycles / 300) % 4)
            0: pts_ch.ready <= 1'b1;
            1: pts_ch.ready <= ($urandom_range(1, 0) == 1);
            2: pts_ch.ready <= (cycles % 7 == 0);
            default: pts_ch.ready <= ($urandom_range(9, 0) != 0);
        endcase
    end

    // request monitors on both channels
    always @(posedge i_clk) begin
        point_t a;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) board.note_byte(in_ch.payload_byte, in_ch.last_byte);
            if (pts_ch.valid && pts_ch.ready) begin
                a.point_time      = pts_ch.point_time;
                a.x_pos           = pts_ch.x_pos;
                a.y_pos           = pts_ch.y_pos;
                a.z_pos           = pts_ch.z_pos;
                a.range_raw       = pts_ch.range_raw;
                a.reflectance_raw = pts_ch.reflectance_raw;
                a.angles_raw      = pts_ch.angles_raw;
                a.return_position = pts_ch.return_position;
                a.scan_line       = pts_ch.scan_line;
                a.exist_pct       = pts_ch.exist_pct;
                a.ray_flags       = pts_ch.ray_flags;
                a.packet_tags     = pts_ch.packet_tags;
                board.check_point(a);
            end
        end
    end

    task automatic put_header(bit [7:0] major, bit [7:0] minor, bit [7:0] nrays);
        bit [127:0] h;
        h = {$urandom, $urandom, $urandom, $urandom};
        h[7:0] = major;
        h[15:8] = minor;
        h[39:32] = nrays;
        for (int i = 0; i < 16; i++) pkt_q.insert(pkt_q.size(), h[8*i +: 8]);
    endtask

    task automatic put_ray(bit [15:0] az, bit [15:0] el, bit [3:0] nret);
        bit [127:0] r;
        r = {$urandom, $urandom, $urandom, $urandom};
        r[15:0] = az;
        r[31:16] = el;
        r[79:76] = nret;
        for (int i = 0; i < 16; i++) pkt_q.insert(pkt_q.size(), r[8*i +: 8]);
    endtask

    task automatic put_return(bit [23:0] rng);
        bit [63:0] r;
        r = {$urandom, $urandom};
        r[31:8] = rng;
        for (int i = 0; i < 8; i++) pkt_q.insert(pkt_q.size(), r[8*i +: 8]);
    endtask

    // sends the built packet, cut to keep bytes when keep > 0
    task automatic send_packet(int keep = 0);
        int n;
        n = (keep > 0 && keep < pkt_q.size()) ? keep : pkt_q.size();
        for (int i = 0; i < n; i++) begin
            if (burst_left == 0) begin
                burst_left = (($urandom_range(3, 0) == 0) ? 200 : $urandom_range(12, 1));
                if ($urandom_range(2, 0) != 0) begin
                    in_ch.valid <= 1'b0;
                    repeat ($urandom_range(8, 1)) @(posedge i_clk);
                end
            end
            burst_left--;
            in_ch.valid        <= 1'b1;
            in_ch.payload_byte <= pkt_q[i];
            in_ch.last_byte    <= (i == n - 1);
            do @(posedge i_clk); while (!in_ch.ready);
            bytes_sent++;
        end
        pkt_q.delete();
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.due_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic bit [15:0] pick_angle();
        case ($urandom_range(5, 0))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'(16'h6488 + $urandom_range(4, 0) - 2);
            3: return 16'(16'h9B78 + $urandom_range(4, 0) - 2);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic bit [23:0] pick_range();
        case ($urandom_range(5, 0))
            0: return 24'hFFFFFF;
            1: return 24'd0;
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        int nrays, nret, keep, pkts;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.payload_byte <= 8'd0;
        in_ch.last_byte    <= 1'b0;
        burst_left = 0;
        bytes_sent = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // short packet that ends inside the header
        put_header(8'd1, 8'd3, 8'd1);
        send_packet(9);
        // wrong version, rest ignored
        put_header(8'd1, 8'd2, 8'd1);
        put_ray(16'd0, 16'd0, 4'd1);
        put_return(24'hFFFFFF);
        send_packet();
        // no rays
        put_header(8'd1, 8'd3, 8'd0);
        put_return(24'h1234);
        send_packet();
        // angle and range extremes, zero-return ray, trailing bytes
        put_header(8'd1, 8'd3, 8'd3);
        put_ray(16'h7FFF, 16'h8000, 4'd2);
        put_return(24'hFFFFFF);
        put_return(24'd0);
        put_ray(16'h0000, 16'h6488, 4'd0);
        put_ray(16'h8000, 16'h7FFF, 4'd1);
        put_return(24'hFFFFFF);
        repeat (5) pkt_q.insert(pkt_q.size(), 8'($urandom));
        send_packet();
        // return cut short by the last byte
        put_header(8'd1, 8'd3, 8'd1);
        put_ray(16'h4000, 16'hC000, 4'd2);
        put_return(24'h800000);
        put_return(24'h7FFFFF);
        send_packet(16 + 16 + 8 + 5);
        drain();

        pkts = 0;
        while (bytes_sent < BYTE_GOAL) begin
            pkts++;
            nrays = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(3, 1);
            if ($urandom_range(7, 0) == 0) put_header(8'($urandom), 8'($urandom), 8'(nrays));
            else put_header(8'd1, 8'd3, 8'(nrays));
            for (int r = 0; r < nrays; r++) begin
                nret = ($urandom_range(15, 0) == 0) ? $urandom_range(15, 4)
                                                    : $urandom_range(3, 0);
                put_ray(pick_angle(), pick_angle(), 4'(nret));
                for (int k = 0; k < nret; k++) put_return(pick_range());
            end
            if ($urandom_range(9, 0) == 0)
                repeat ($urandom_range(20, 1)) pkt_q.insert(pkt_q.size(), 8'($urandom));
            keep = ($urandom_range(6, 0) == 0) ? $urandom_range(pkt_q.size(), 1) : 0;
            send_packet(keep);
            if (pkts % 6 == 0) drain();
        end

        drain();
        while (board.due_q.size() != 0) begin
            $display("%0t: point expected but never seen %h", $time, board.due_q[0]);
            board.due_q.delete(0);
            board.errors++;
        end
        if (board.errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
rtl/ldr_pkg.sv
rtl/ldr_if.sv
rtl/ldr_ctrl.sv
rtl/ldr_dp.sv
rtl/lidar_return_decoder_unit.sv
dv/lidar_return_decoder_unit_tb.sv
